// ----- sv/send_window_tracking_table_macros.svh -----
// ----------------------------------------------------------------------------
// send window tracking table assertion macros
// shared property forms for the checks at the end of the top rtl module
// ----------------------------------------------------------------------------
`ifndef SEND_WINDOW_TRACKING_TABLE_MACROS_SVH
`define SEND_WINDOW_TRACKING_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SWTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swtt check failed");

// consequent must hold in the cycle after the antecedent
`define SWTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swtt check failed");

`endif

// ----- sv/swtt_pkg.sv -----
// ----------------------------------------------------------------------------
// swtt_pkg
// types and constants shared by the send window tracking table modules
// ----------------------------------------------------------------------------
package swtt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int WIN_W           = 7;
  localparam int SLOT_W          = 6;
  localparam int OP_W            = 2;
  localparam int USEC_W          = 20;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] secs;
    logic [31:0] seqno;
  } key_t;

  typedef struct packed {
    logic [31:0]       secs;
    logic [USEC_W-1:0] usec;
    logic [31:0]       ident;
  } entry_t;

  typedef struct packed {
    logic key_we;
    logic key_re;
    logic data_we;
    logic data_re;
  } mem_ctl_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic skip;
    logic match_en;
  } scan_ctl_t;

endpackage

// ----- sv/swtt_store.sv -----
// ----------------------------------------------------------------------------
// swtt_store
// key memory and entry memory, one write and one registered read each
// ----------------------------------------------------------------------------
module swtt_store #(
  parameter int TABLE_DEPTH = swtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  swtt_pkg::mem_ctl_t              mem_ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  key_waddr,
  input  swtt_pkg::key_t                  key_wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  key_raddr,
  output swtt_pkg::key_t                  key_rdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  data_addr,
  input  swtt_pkg::entry_t                data_wdata,
  output swtt_pkg::entry_t                data_rdata
);

  swtt_pkg::key_t   key_mem  [TABLE_DEPTH];
  swtt_pkg::entry_t data_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (mem_ctl.key_re) begin
      key_rdata <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.data_we) begin
      data_mem[data_addr] <= data_wdata;
    end
    if (mem_ctl.data_re) begin
      data_rdata <= data_mem[data_addr];
    end
  end

endmodule

// ----- sv/swtt_scan.sv -----
// ----------------------------------------------------------------------------
// swtt_scan
// shared key comparator: first match in scan order and occupied count
// ----------------------------------------------------------------------------
module swtt_scan #(
  parameter int TABLE_DEPTH = swtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  swtt_pkg::scan_ctl_t              scan_ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   cmp_addr,
  input  swtt_pkg::key_t                   stored,
  input  swtt_pkg::key_t                   target,
  output logic                             hit,
  output logic [$clog2(TABLE_DEPTH)-1:0]   hit_slot,
  output logic [swtt_pkg::WIN_W-1:0]       cnt
);

  logic key_eq;
  logic secs_set;

  assign key_eq   = (stored == target);
  assign secs_set = (stored.secs != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      cnt <= '0;
    end else if (scan_ctl.clear) begin
      hit <= 1'b0;
      cnt <= '0;
    end else if (scan_ctl.valid) begin
      // a slot being removed is counted as already free
      if (secs_set && !scan_ctl.skip) begin
        cnt <= cnt + swtt_pkg::WIN_W'(1);
      end
      if (scan_ctl.match_en && key_eq && !hit) begin
        hit      <= 1'b1;
        hit_slot <= cmp_addr;
      end
    end
  end

endmodule

// ----- sv/send_window_tracking_table.sv -----
// ----------------------------------------------------------------------------
// send_window_tracking_table
// table of in-flight transmissions keyed by creation timestamp
// ----------------------------------------------------------------------------
// Each operation walks every slot of the active window once, one slot per
// cycle through a single key comparator, starting after the last insert or
// the last hit; the walk finds the first free or matching slot and counts
// occupied slots at the same time. An item runs from accept through the
// scan, fetch and done states before the next accept, paced by the one read
// port of the key memory and the registered compare behind it. If the
// previous result is still stalled on the output when the new one is ready,
// the item waits in the done state until that result is taken. After reset
// the key memory is swept to zero before the first item is taken; config
// writes are taken during the sweep. A result waiting on the output does
// not hold off the next item.
module send_window_tracking_table #(
  parameter int TABLE_DEPTH = swtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [swtt_pkg::WIN_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [swtt_pkg::OP_W-1:0]     operation,
  input  logic [31:0]                   key_secs,
  input  logic [31:0]                   key_seqno,
  input  logic [31:0]                   send_secs,
  input  logic [swtt_pkg::USEC_W-1:0]   send_usec,
  input  logic [swtt_pkg::SLOT_W-1:0]   slot_to_free,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    status,
  output logic [swtt_pkg::SLOT_W-1:0]   slot,
  output logic [31:0]                   entry_id,
  output logic [31:0]                   found_send_secs,
  output logic [swtt_pkg::USEC_W-1:0]   found_send_usec,
  output logic [swtt_pkg::WIN_W-1:0]    occupied_count
);

  `include "send_window_tracking_table_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int WIN_W = swtt_pkg::WIN_W;
  localparam int CMP_W = (IDX_W + 1 > WIN_W) ? IDX_W + 1 : WIN_W;
  localparam int PW    = (IDX_W + 1 > swtt_pkg::SLOT_W) ? IDX_W + 1 : swtt_pkg::SLOT_W;

  swtt_pkg::state_t    state, state_next;
  swtt_pkg::mem_ctl_t  mem_ctl;
  swtt_pkg::scan_ctl_t scan_ctl;

  logic [WIN_W-1:0]            window_in_use;
  logic [swtt_pkg::OP_W-1:0]   op;
  logic [31:0]                 k_secs;
  logic [31:0]                 k_seqno;
  logic [31:0]                 s_secs;
  logic [swtt_pkg::USEC_W-1:0] s_usec;
  logic [swtt_pkg::SLOT_W-1:0] pos;
  logic [WIN_W-1:0]            win;
  logic [IDX_W-1:0]            addr;
  logic [WIN_W-1:0]            rem;
  logic                        pend;
  logic [IDX_W-1:0]            tag;
  logic [IDX_W-1:0]            last_ins;
  logic                        last_ins_ok;
  logic [IDX_W-1:0]            last_hit;
  logic                        last_hit_ok;
  logic [31:0]                 next_ident;
  logic [1:0]                  res_status;
  logic [swtt_pkg::SLOT_W-1:0] res_slot;
  logic [31:0]                 res_id;
  logic [WIN_W-1:0]            res_count;
  logic                        res_data;

  logic [CMP_W-1:0]     win_full;
  logic [WIN_W-1:0]     win_in;
  logic [IDX_W-1:0]     last_sel;
  logic                 last_ok_sel;
  logic [CMP_W-1:0]     last_inc;
  logic [CMP_W-1:0]     start_full;
  logic [CMP_W-1:0]     addr_inc;
  logic [IDX_W-1:0]     addr_wrap;
  logic [PW-1:0]        pos_x;
  logic                 pos_ok;
  logic [PW-1:0]        hit_x;
  logic                 is_insert;
  logic                 is_lookup;
  logic                 is_remove;
  logic                 key_zero;
  logic                 load;

  logic                 hit;
  logic [IDX_W-1:0]     hit_slot;
  logic [WIN_W-1:0]     cnt;
  logic [IDX_W-1:0]     key_waddr;
  swtt_pkg::key_t       key_wdata;
  swtt_pkg::key_t       key_rdata;
  swtt_pkg::key_t       target;
  swtt_pkg::entry_t     data_wdata;
  swtt_pkg::entry_t     data_rdata;

  // effective window and scan start, evaluated at accept
  assign win_full = (CMP_W'(window_in_use) < CMP_W'(TABLE_DEPTH)) ?
                    CMP_W'(window_in_use) : CMP_W'(TABLE_DEPTH);
  assign win_in   = win_full[WIN_W-1:0];

  assign last_sel    = (operation == swtt_pkg::OP_INSERT) ? last_ins : last_hit;
  assign last_ok_sel = (operation == swtt_pkg::OP_INSERT) ? last_ins_ok : last_hit_ok;
  assign last_inc    = CMP_W'(last_sel) + CMP_W'(1);
  assign start_full  = (!last_ok_sel || last_inc >= CMP_W'(win_in)) ? '0 : last_inc;

  assign addr_inc  = CMP_W'(addr) + CMP_W'(1);
  assign addr_wrap = (addr_inc == CMP_W'(win)) ? '0 : addr_inc[IDX_W-1:0];

  assign pos_x  = PW'(pos);
  assign pos_ok = (pos_x < PW'(TABLE_DEPTH));
  assign hit_x  = PW'(hit_slot);

  assign is_insert = (op == swtt_pkg::OP_INSERT);
  assign is_lookup = (op == swtt_pkg::OP_LOOKUP);
  assign is_remove = (op == swtt_pkg::OP_REMOVE);
  assign key_zero  = (k_secs == '0) && (k_seqno == '0);

  // insert looks for an all-zero key, lookup for the given key
  assign target = is_insert ? '0 : swtt_pkg::key_t'({k_secs, k_seqno});

  assign load       = !result_valid || !result_stall;
  assign item_stall = (state != swtt_pkg::ST_IDLE);

  always_comb begin
    if (state == swtt_pkg::ST_CLEAR) begin
      key_waddr = addr;
      key_wdata = '0;
    end else if (is_insert) begin
      key_waddr = hit_slot;
      key_wdata = swtt_pkg::key_t'({k_secs, k_seqno});
    end else begin
      key_waddr = pos_x[IDX_W-1:0];
      key_wdata = '0;
    end
  end

  assign data_wdata = swtt_pkg::entry_t'({s_secs, s_usec, next_ident});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    mem_ctl           = '0;
    scan_ctl          = '0;
    scan_ctl.skip     = is_remove && (PW'(tag) == pos_x);
    scan_ctl.match_en = is_insert || (is_lookup && !key_zero);
    case (state)
      swtt_pkg::ST_CLEAR: begin
        mem_ctl.key_we = 1'b1;
        if (addr == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = swtt_pkg::ST_IDLE;
        end
      end
      swtt_pkg::ST_IDLE: begin
        if (item_valid) begin
          scan_ctl.clear = 1'b1;
          state_next     = swtt_pkg::ST_SCAN;
        end
      end
      swtt_pkg::ST_SCAN: begin
        mem_ctl.key_re = (rem != '0);
        scan_ctl.valid = pend;
        if (rem == '0 && !pend) begin
          state_next = swtt_pkg::ST_FETCH;
        end
      end
      swtt_pkg::ST_FETCH: begin
        mem_ctl.key_we  = (is_insert && hit) || (is_remove && pos_ok);
        mem_ctl.data_we = is_insert && hit;
        mem_ctl.data_re = is_lookup && hit;
        state_next      = swtt_pkg::ST_DONE;
      end
      swtt_pkg::ST_DONE: begin
        if (load) begin
          state_next = swtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_in_use <= swtt_pkg::WINDOW_RESET;
      addr          <= '0;
      rem           <= '0;
      pend          <= 1'b0;
      last_ins_ok   <= 1'b0;
      last_hit_ok   <= 1'b0;
      next_ident    <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        window_in_use <= cfg_data;
      end
      if (state == swtt_pkg::ST_DONE && load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        swtt_pkg::ST_CLEAR: begin
          addr <= addr + IDX_W'(1);
        end
        swtt_pkg::ST_IDLE: begin
          if (item_valid) begin
            op      <= operation;
            k_secs  <= key_secs;
            k_seqno <= key_seqno;
            s_secs  <= send_secs;
            s_usec  <= send_usec;
            pos     <= slot_to_free;
            win     <= win_in;
            addr    <= start_full[IDX_W-1:0];
            // remove and no-op still walk the window for the count
            rem     <= win_in;
            pend    <= 1'b0;
          end
        end
        swtt_pkg::ST_SCAN: begin
          if (rem != '0) begin
            tag  <= addr;
            addr <= addr_wrap;
            rem  <= rem - WIN_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        swtt_pkg::ST_FETCH: begin
          res_status <= swtt_pkg::STAT_OK;
          res_slot   <= '0;
          res_id     <= '0;
          res_count  <= cnt;
          res_data   <= 1'b0;
          case (op)
            swtt_pkg::OP_INSERT: begin
              if (hit) begin
                res_slot    <= hit_x[swtt_pkg::SLOT_W-1:0];
                res_id      <= next_ident;
                // a free slot was not counted; count it if the written key has nonzero secs
                res_count   <= cnt + WIN_W'(k_secs != '0);
                last_ins    <= hit_slot;
                last_ins_ok <= 1'b1;
                next_ident  <= next_ident + 32'd1;
              end else begin
                res_status <= swtt_pkg::STAT_FULL;
              end
            end
            swtt_pkg::OP_LOOKUP: begin
              if (hit) begin
                res_slot    <= hit_x[swtt_pkg::SLOT_W-1:0];
                res_data    <= 1'b1;
                last_hit    <= hit_slot;
                last_hit_ok <= 1'b1;
              end else begin
                res_status <= swtt_pkg::STAT_MISS;
              end
            end
            swtt_pkg::OP_REMOVE: begin
              res_slot <= pos;
            end
            default: begin
              res_slot <= '0;
            end
          endcase
        end
        swtt_pkg::ST_DONE: begin
          if (load) begin
            status          <= res_status;
            slot            <= res_slot;
            occupied_count  <= res_count;
            entry_id        <= res_data ? data_rdata.ident : res_id;
            found_send_secs <= res_data ? data_rdata.secs : '0;
            found_send_usec <= res_data ? data_rdata.usec : '0;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  swtt_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (addr),
    .key_rdata  (key_rdata),
    .data_addr  (hit_slot),
    .data_wdata (data_wdata),
    .data_rdata (data_rdata)
  );

  swtt_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .scan_ctl (scan_ctl),
    .cmp_addr (tag),
    .stored   (key_rdata),
    .target   (target),
    .hit      (hit),
    .hit_slot (hit_slot),
    .cnt      (cnt)
  );

  `SWTT_ASSERT_NEXT(a_accept_scan, clk, rst, item_valid && !item_stall, state == swtt_pkg::ST_SCAN)
  `SWTT_ASSERT_NOW(a_rem_scan, clk, rst, rem != '0, state == swtt_pkg::ST_SCAN)
  `SWTT_ASSERT_NOW(a_no_write_scan, clk, rst, state == swtt_pkg::ST_SCAN, !mem_ctl.key_we && !mem_ctl.data_we)
  `SWTT_ASSERT_NOW(a_full_fields, clk, rst, result_valid && status == swtt_pkg::STAT_FULL, slot == '0 && entry_id == '0)

endmodule

// ----- dv/send_window_tracking_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// send_window_tracking_table_checker
// watches the item and result channels of the send window tracking table,
// keeps its own copy of the table and window, predicts the result of every
// accepted beat and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module send_window_tracking_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [swtt_pkg::WIN_W-1:0]  cfg_data,
  input  logic                        item_valid,
  input  logic                        item_stall,
  input  logic [swtt_pkg::OP_W-1:0]   operation,
  input  logic [31:0]                 key_secs,
  input  logic [31:0]                 key_seqno,
  input  logic [31:0]                 send_secs,
  input  logic [swtt_pkg::USEC_W-1:0] send_usec,
  input  logic [swtt_pkg::SLOT_W-1:0] slot_to_free,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  logic [1:0]                  status,
  input  logic [swtt_pkg::SLOT_W-1:0] slot,
  input  logic [31:0]                 entry_id,
  input  logic [31:0]                 found_send_secs,
  input  logic [swtt_pkg::USEC_W-1:0] found_send_usec,
  input  logic [swtt_pkg::WIN_W-1:0]  occupied_count,
  output int                          pending,
  output int                          failures
);
  import swtt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       ident;
    logic [31:0]       secs;
    logic [USEC_W-1:0] usec;
    logic [WIN_W-1:0]  count;
  } outcome_t;

  // table copy
  logic [31:0]       held_secs  [DEPTH];
  logic [31:0]       held_seqno [DEPTH];
  logic [31:0]       sent_secs  [DEPTH];
  logic [USEC_W-1:0] sent_usec  [DEPTH];
  logic [31:0]       held_ident [DEPTH];
  logic [WIN_W-1:0]  window_reg;
  int                ins_last;
  bit                ins_seen;
  int                hit_last;
  bit                hit_seen;
  logic [31:0]       ident_next;

  outcome_t outcome_q[$];

  task automatic flag(string what);
    if (failures < 50) $display("%0t ns: %s", $time, what);
    failures++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  function automatic outcome_t table_outcome(op_t op, logic [31:0] ks, logic [31:0] kq,
                                              logic [31:0] ss, logic [USEC_W-1:0] su,
                                              logic [SLOT_W-1:0] pos);
    outcome_t o;
    int       win;
    int       start;
    int       idx;
    int       n;
    bit       done;
    o = '0;
    o.status = STAT_OK;
    done = 1'b0;
    win = (window_reg < DEPTH) ? int'(window_reg) : DEPTH;
    case (op)
      OP_INSERT: begin
        start = (!ins_seen || ins_last + 1 >= win) ? 0 : ins_last + 1;
        o.status = STAT_FULL;
        for (int k = 0; k < win; k++) begin
          idx = (start + k) % win;
          if (!done && held_secs[idx] == 32'd0 && held_seqno[idx] == 32'd0) begin
            held_secs[idx]  = ks;
            held_seqno[idx] = kq;
            sent_secs[idx]  = ss;
            sent_usec[idx]  = su;
            held_ident[idx] = ident_next;
            ins_last = idx;
            ins_seen = 1'b1;
            o.status = STAT_OK;
            o.slot   = SLOT_W'(idx);
            o.ident  = ident_next;
            ident_next = ident_next + 32'd1;
            done = 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        start = (!hit_seen || hit_last + 1 >= win) ? 0 : hit_last + 1;
        o.status = STAT_MISS;
        // a zero key is a free slot and never matches
        if (ks != 32'd0 || kq != 32'd0) begin
          for (int k = 0; k < win; k++) begin
            idx = (start + k) % win;
            if (!done && held_secs[idx] == ks && held_seqno[idx] == kq) begin
              hit_last = idx;
              hit_seen = 1'b1;
              o.status = STAT_OK;
              o.slot   = SLOT_W'(idx);
              o.ident  = held_ident[idx];
              o.secs   = sent_secs[idx];
              o.usec   = sent_usec[idx];
              done = 1'b1;
            end
          end
        end
      end
      OP_REMOVE: begin
        // cleared by position, window or not
        held_secs[pos]  = 32'd0;
        held_seqno[pos] = 32'd0;
        o.slot = pos;
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < win; i++) if (held_secs[i] != 32'd0) n++;
    o.count = WIN_W'(n);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        held_secs[i]  = '0;
        held_seqno[i] = '0;
        sent_secs[i]  = '0;
        sent_usec[i]  = '0;
        held_ident[i] = '0;
      end
      window_reg = WINDOW_RESET;
      ins_last   = 0;
      ins_seen   = 1'b0;
      hit_last   = 0;
      hit_seen   = 1'b0;
      ident_next = '0;
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (cfg_write) window_reg = cfg_data;
      if (item_valid && !item_stall) begin
        outcome_q.push_back(table_outcome(op_t'(operation), key_secs, key_seqno,
                                          send_secs, send_usec, slot_to_free));
      end
      if (result_valid && !result_stall) begin
        if (outcome_q.size() == 0) begin
          flag("result beat with no outstanding item");
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", 32'(status), 32'(want.status));
          compare_field("slot", 32'(slot), 32'(want.slot));
          compare_field("entry_id", entry_id, want.ident);
          compare_field("found_send_secs", found_send_secs, want.secs);
          compare_field("found_send_usec", 32'(found_send_usec), 32'(want.usec));
          compare_field("occupied_count", 32'(occupied_count), 32'(want.count));
        end
      end
      pending <= outcome_q.size();
    end
  end

  initial failures = 0;

endmodule

// ----- dv/tb_send_window_tracking_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_send_window_tracking_table
// drives insert, lookup, remove and idle beats into the tracking table under
// several window sizes with random gaps and result stalls; the checker beside
// the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_send_window_tracking_table;
  import swtt_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int POOL            = 32;
  localparam int PHASE_BEATS     = 183;
  localparam int SETTLE_CYCLES   = 80;
  localparam int NUM_PHASES      = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [WIN_W-1:0]  cfg_data = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [OP_W-1:0]   operation = '0;
  logic [31:0]       key_secs = '0;
  logic [31:0]       key_seqno = '0;
  logic [31:0]       send_secs = '0;
  logic [USEC_W-1:0] send_usec = '0;
  logic [SLOT_W-1:0] slot_to_free = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       entry_id;
  logic [31:0]       found_send_secs;
  logic [USEC_W-1:0] found_send_usec;
  logic [WIN_W-1:0]  occupied_count;

  int pending_beats;
  int fail_count;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  int win_now = 64;

  logic [63:0] key_pool [POOL];
  int          pool_next = 0;

  send_window_tracking_table u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .operation       (operation),
    .key_secs        (key_secs),
    .key_seqno       (key_seqno),
    .send_secs       (send_secs),
    .send_usec       (send_usec),
    .slot_to_free    (slot_to_free),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .slot            (slot),
    .entry_id        (entry_id),
    .found_send_secs (found_send_secs),
    .found_send_usec (found_send_usec),
    .occupied_count  (occupied_count)
  );

  send_window_tracking_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .operation       (operation),
    .key_secs        (key_secs),
    .key_seqno       (key_seqno),
    .send_secs       (send_secs),
    .send_usec       (send_usec),
    .slot_to_free    (slot_to_free),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .slot            (slot),
    .entry_id        (entry_id),
    .found_send_secs (found_send_secs),
    .found_send_usec (found_send_usec),
    .occupied_count  (occupied_count),
    .pending         (pending_beats),
    .failures        (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("send_window_tracking_table: mismatch");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end
  end

  // valid stays up between back-to-back beats, dropped only for a gap
  task automatic send_beat(op_t op, logic [31:0] ks, logic [31:0] kq, logic [31:0] ss,
                           logic [USEC_W-1:0] su, logic [SLOT_W-1:0] pos);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= op;
    key_secs     <= ks;
    key_seqno    <= kq;
    send_secs    <= ss;
    send_usec    <= su;
    slot_to_free <= pos;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
  endtask

  // drain outstanding results before touching the window
  task automatic set_window(int w);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= WIN_W'(w);
    @(posedge clk);
    cfg_write <= 1'b0;
    win_now = w;
  endtask

  task automatic random_beat();
    int                r;
    int                pick;
    logic [31:0]       ks;
    logic [31:0]       kq;
    logic [31:0]       ss;
    logic [USEC_W-1:0] su;
    logic [SLOT_W-1:0] pos;
    op_t               op;
    ks   = $urandom;
    kq   = $urandom;
    ss   = $urandom;
    su   = $urandom_range(0, 1) ? USEC_W'($urandom_range(0, 999999)) : USEC_W'($urandom);
    pos  = SLOT_W'($urandom_range(0, 63));
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0: ss = '0;
      1: ss = '1;
      default: ;
    endcase
    if (r < 45) op = OP_INSERT;
    else if (r < 78) op = OP_LOOKUP;
    else if (r < 95) op = OP_REMOVE;
    else op = OP_NOP;
    case (op)
      OP_INSERT: begin
        case (pick)
          0: {ks, kq} = '0;
          1: ks = '0;
          2: kq = '0;
          3: {ks, kq} = key_pool[$urandom_range(0, POOL - 1)];
          4: begin
            ks = $urandom_range(1, 3);
            kq = $urandom_range(0, 3);
          end
          5: {ks, kq} = '1;
          default: ;
        endcase
        key_pool[pool_next] = {ks, kq};
        pool_next = (pool_next + 1) % POOL;
      end
      OP_LOOKUP: begin
        if (pick < 7) begin
          {ks, kq} = key_pool[$urandom_range(0, POOL - 1)];
        end else if (pick == 7) begin
          {ks, kq} = '0;
        end else if (pick == 8) begin
          ks = $urandom_range(0, 3);
          kq = $urandom_range(0, 3);
        end
      end
      OP_REMOVE: begin
        // mostly inside the window, sometimes beyond it
        if (pick < 8) pos = SLOT_W'($urandom_range(0, win_now - 1));
      end
      default: ;
    endcase
    send_beat(op, ks, kq, ss, su, pos);
  endtask

  initial begin
    int windows [NUM_PHASES];
    int w;
    windows = '{1, 2, 64, 7, 33, 1, 64, 0, 0, 64};
    for (int i = 0; i < POOL; i++) key_pool[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed opening at the reset window
    send_beat(OP_LOOKUP, '0, '0, '1, '1, '1);
    send_beat(OP_INSERT, '1, '1, '1, '1, '0);
    send_beat(OP_INSERT, 32'd0, 32'd5, '0, '0, '1);
    send_beat(OP_INSERT, '0, '0, 32'h1234_5678, 20'd7, '0);
    send_beat(OP_INSERT, 32'd1, 32'd0, 32'hdead_beef, 20'd999999, 6'd17);
    send_beat(OP_INSERT, 32'h8000_0000, 32'h0000_0001, '0, 20'h80000, 6'd40);
    send_beat(OP_LOOKUP, '1, '1, '0, '0, '0);
    send_beat(OP_LOOKUP, 32'd0, 32'd5, '0, '0, '0);
    send_beat(OP_LOOKUP, '0, '0, '0, '0, '0);
    send_beat(OP_LOOKUP, 32'd1, 32'd0, '0, '0, '0);
    send_beat(OP_LOOKUP, 32'h8000_0000, 32'h0000_0001, '0, '0, '0);
    send_beat(OP_LOOKUP, 32'h1234, 32'h5678, '1, '1, '1);
    send_beat(OP_REMOVE, '1, '1, '1, '1, 6'd0);
    send_beat(OP_REMOVE, '0, '0, '0, '0, 6'd63);
    send_beat(OP_LOOKUP, '1, '1, '0, '0, '0);
    send_beat(OP_NOP, '1, '1, '1, '1, '1);
    send_beat(OP_INSERT, 32'h0000_0002, 32'hffff_ffff, '1, '0, '0);
    send_beat(OP_REMOVE, '0, '0, '0, '0, 6'd1);
    send_beat(OP_INSERT, 32'h7fff_ffff, 32'd0, 32'h5555_5555, 20'haaaaa, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (windows[p] == 0) ? $urandom_range(3, 63) : windows[p];
      set_window(w);
      idle_on <= (p != 4 && p != NUM_PHASES - 1);
      repeat (PHASE_BEATS) random_beat();
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("send_window_tracking_table: match");
    end else begin
      $display("send_window_tracking_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- send_window_tracking_table.f -----
+incdir+sv
sv/swtt_pkg.sv
sv/swtt_store.sv
sv/swtt_scan.sv
sv/send_window_tracking_table.sv
dv/send_window_tracking_table_checker.sv
dv/tb_send_window_tracking_table.sv
